// ===== design/utf8_text_sanitizer_macros.svh =====
// Assertion macros used by the UTF-8 text sanitizer top level
`ifndef UTF8_TEXT_SANITIZER_MACROS_SVH
`define UTF8_TEXT_SANITIZER_MACROS_SVH

// same-cycle implication, checked outside reset
`define UTS_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("utf8 text sanitizer: assertion failed");

// next-cycle implication, checked outside reset
`define UTS_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("utf8 text sanitizer: assertion failed");

`endif

// ===== design/utf8ts_pkg.sv =====
// Types, constants and helper functions for the UTF-8 text sanitizer
package utf8ts_pkg;

   localparam int unsigned MaxOut = 5;

   localparam logic [7:0] MarkLead    = 8'hc2;
   localparam logic [7:0] MarkTail    = 8'ha7;
   localparam logic [7:0] SpaceByte   = 8'd32;
   localparam logic [7:0] DelByte     = 8'd127;
   localparam logic [7:0] Lead2Last   = 8'hdf;
   localparam logic [7:0] Lead3First  = 8'he0;
   localparam logic [7:0] Lead3Last   = 8'hef;
   localparam logic [7:0] Lead4First  = 8'hf0;
   localparam logic [7:0] Lead4Last   = 8'hf4;
   localparam logic [7:0] SurrLead    = 8'hed;
   localparam logic [7:0] Cont3Limit  = 8'ha0;
   localparam logic [7:0] Cont4Limit  = 8'h90;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       final_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       end_of_text;
   } rsp_type;

   typedef struct packed {
      logic [7:0] held_lead;
      logic [1:0] held_count;
      logic       skip_following;
      logic       space_owed;
      logic       anything_written;
   } state_type;

   typedef logic [1:0][7:0] conts_type;

   typedef struct packed {
      logic [MaxOut-1:0][7:0] bytes;
      logic [2:0]             count;
      logic                   bare;
      logic                   eot;
   } bundle_type;

   localparam state_type StateReset = '{
      held_lead:        8'd0,
      held_count:       2'd0,
      skip_following:   1'b0,
      space_owed:       1'b0,
      anything_written: 1'b0
   };

   function automatic logic [2:0] seq_len(input logic [7:0] b);
      logic [2:0] len;
      begin
         len = 3'd0;
         if (b[7] == 1'b0) begin
            len = 3'd1;
         end else if (b >= MarkLead && b <= Lead2Last) begin
            len = 3'd2;
         end else if (b >= Lead3First && b <= Lead3Last) begin
            len = 3'd3;
         end else if (b >= Lead4First && b <= Lead4Last) begin
            len = 3'd4;
         end
         return len;
      end
   endfunction

endpackage

// ===== design/utf8ts_step.sv =====
// Next-state and result-bundle logic for one input byte of the sanitizer
module utf8ts_step
   import utf8ts_pkg::*;
(
   input  state_type  state,
   input  conts_type  conts,
   input  req_type    req,
   output state_type  state_next,
   output conts_type  conts_next,
   output bundle_type bundle
);

   logic [7:0] b;
   logic [2:0] lead_len;
   logic [2:0] fresh_len;
   logic       cont_ok;
   logic       fresh;
   logic       emit_seq;
   logic [2:0] n;
   logic [MaxOut-1:0][7:0] bytes;

   assign b         = req.data_byte;
   assign lead_len  = seq_len(state.held_lead);
   assign fresh_len = seq_len(b);

   always_comb begin
      cont_ok = (b[7:6] == 2'b10);
      if (state.held_count == 2'd1 && lead_len >= 3'd3) begin
         if ((state.held_lead == Lead3First && b <  Cont3Limit) ||
             (state.held_lead == SurrLead   && b >= Cont3Limit) ||
             (state.held_lead == Lead4First && b <  Cont4Limit) ||
             (state.held_lead == Lead4Last  && b >= Cont4Limit)) begin
            cont_ok = 1'b0;
         end
      end
   end

   always_comb begin
      state_next = state;
      conts_next = conts;
      fresh      = 1'b0;
      emit_seq   = 1'b0;
      n          = 3'd0;
      bytes      = '0;

      if (state.skip_following) begin
         state_next.skip_following = 1'b0;
      end else if (state.held_count != 2'd0) begin
         if (state.held_lead == MarkLead && state.held_count == 2'd1 && b == MarkTail) begin
            state_next.held_count     = 2'd0;
            state_next.skip_following = 1'b1;
         end else if (!cont_ok) begin
            state_next.held_count = 2'd0;
            fresh                 = 1'b1;
         end else if ({1'b0, state.held_count} + 3'd1 >= lead_len) begin
            emit_seq              = 1'b1;
            state_next.held_count = 2'd0;
         end else begin
            conts_next[state.held_count[1]] = b;
            state_next.held_count = state.held_count + 2'd1;
         end
      end else begin
         fresh = 1'b1;
      end

      if (fresh) begin
         if (b <= SpaceByte || b == DelByte) begin
            state_next.space_owed = state.anything_written;
         end else if (fresh_len == 3'd1) begin
            if (state.space_owed) begin
               bytes[n] = SpaceByte;
               n        = n + 3'd1;
            end
            bytes[n] = b;
            n        = n + 3'd1;
            state_next.space_owed       = 1'b0;
            state_next.anything_written = 1'b1;
         end else if (fresh_len != 3'd0) begin
            state_next.held_lead  = b;
            state_next.held_count = 2'd1;
         end
      end

      if (emit_seq) begin
         if (state.space_owed) begin
            bytes[n] = SpaceByte;
            n        = n + 3'd1;
         end
         bytes[n] = state.held_lead;
         n        = n + 3'd1;
         if (state.held_count >= 2'd2) begin
            bytes[n] = conts[0];
            n        = n + 3'd1;
         end
         if (state.held_count == 2'd3) begin
            bytes[n] = conts[1];
            n        = n + 3'd1;
         end
         bytes[n] = b;
         n        = n + 3'd1;
         state_next.space_owed       = 1'b0;
         state_next.anything_written = 1'b1;
      end

      bundle.bytes = bytes;
      bundle.count = n;
      bundle.bare  = 1'b0;
      bundle.eot   = req.final_byte;
      if (req.final_byte) begin
         state_next = StateReset;
         if (n == 3'd0) begin
            bundle.count = 3'd1;
            bundle.bare  = 1'b1;
         end
      end
   end

endmodule

// ===== design/utf8_text_sanitizer.sv =====
// A byte is taken into the input register, judged there, and shown from the result register.
// Throughput: one input byte per cycle while each yields at most one result and the receiver
// does not stall; a byte that completes a character holds the input until the single-byte result
// port has drained all of its bytes (up to five) from the result register.
// Reset: synchronous, active high; clears all control state, no clearing pass.
// Top level of the UTF-8 text sanitizer
`include "utf8_text_sanitizer_macros.svh"

module utf8_text_sanitizer
   import utf8ts_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   req_type    in_ff, in_in;
   logic       in_valid_ff, in_valid_in;
   state_type  state_ff, state_in;
   conts_type  conts_ff, conts_in;
   bundle_type bundle_ff, bundle_in;
   logic       bundle_valid_ff, bundle_valid_in;
   logic [2:0] idx_ff, idx_in;

   state_type  state_next;
   conts_type  conts_next;
   bundle_type bundle_next;

   logic take_in;
   logic rsp_xfer;
   logic last_out;
   logic bundle_done;
   logic proc_go;

   utf8ts_step u_step (
      .state      (state_ff),
      .conts      (conts_ff),
      .req        (in_ff),
      .state_next (state_next),
      .conts_next (conts_next),
      .bundle     (bundle_next)
   );

   assign last_out    = (idx_ff == bundle_ff.count - 3'd1);
   assign rsp_xfer    = bundle_valid_ff && !rsp_stall;
   assign bundle_done = rsp_xfer && last_out;
   assign proc_go     = in_valid_ff && (!bundle_valid_ff || bundle_done);
   assign req_stall   = in_valid_ff && !proc_go;
   assign take_in     = req_valid && !req_stall;

   assign rsp_valid            = bundle_valid_ff;
   assign rsp_data.out_byte    = bundle_ff.bare ? 8'd0 : bundle_ff.bytes[idx_ff];
   assign rsp_data.byte_valid  = !bundle_ff.bare;
   assign rsp_data.end_of_text = bundle_ff.eot && last_out;

   always_comb begin
      in_in           = take_in ? req_data : in_ff;
      in_valid_in     = take_in || (in_valid_ff && !proc_go);
      state_in        = proc_go ? state_next : state_ff;
      conts_in        = proc_go ? conts_next : conts_ff;
      bundle_in       = bundle_ff;
      bundle_valid_in = bundle_valid_ff;
      idx_in          = idx_ff;
      if (rsp_xfer && !last_out) begin
         idx_in = idx_ff + 3'd1;
      end
      if (bundle_done) begin
         bundle_valid_in = 1'b0;
      end
      if (proc_go && bundle_next.count != 3'd0) begin
         bundle_in       = bundle_next;
         bundle_valid_in = 1'b1;
         idx_in          = 3'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         state_ff        <= StateReset;
         bundle_valid_ff <= 1'b0;
         idx_ff          <= 3'd0;
      end else begin
         in_valid_ff     <= in_valid_in;
         state_ff        <= state_in;
         bundle_valid_ff <= bundle_valid_in;
         idx_ff          <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      in_ff     <= in_in;
      conts_ff  <= conts_in;
      bundle_ff <= bundle_in;
   end

   `UTS_ASSERT_NEXT(a_reset_after_final, proc_go && in_ff.final_byte,
      state_ff == StateReset)
   `UTS_ASSERT_NOW(a_bare_is_end, rsp_valid && !rsp_data.byte_valid,
      rsp_data.end_of_text)
   `UTS_ASSERT_NOW(a_idx_in_range, bundle_valid_ff,
      idx_ff < bundle_ff.count && bundle_ff.count <= 3'd5)
   `UTS_ASSERT_NOW(a_stall_needs_item, req_stall, in_valid_ff)

endmodule

// ===== test/tb.sv =====
// Testbench for the UTF-8 text sanitizer: directed and random texts checked against a byte predictor
`timescale 1ns / 1ps

module tb
   import utf8ts_pkg::*;
();

   localparam int QuietLimit   = 2000;
   localparam int HoldCycles   = 200;
   localparam int SettleCycles = 8;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   utf8_text_sanitizer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // predicted cleaned-text results, oldest first
   rsp_type    cleaned_q[$];
   logic [7:0] text_q[$];
   logic [7:0] char_q[$];

   logic [7:0] lead_hold  = '0;
   logic [7:0] cont_hold[2];
   logic [1:0] hold_len   = '0;
   logic       skip_next  = 1'b0;
   logic       space_due  = 1'b0;
   logic       wrote_char = 1'b0;
   int         step_bytes;

   int idle_pct    = 0;
   int stall_pct   = 0;
   bit hold_armed  = 1'b0;
   int mismatches  = 0;
   int bytes_sent  = 0;
   int texts_sent  = 0;
   int bytes_out   = 0;
   int markers     = 0;

   function automatic int char_length(logic [7:0] b);
      if (b < 8'h80) return 1;
      if (b >= MarkLead && b <= Lead2Last) return 2;
      if (b >= Lead3First && b <= Lead3Last) return 3;
      if (b >= Lead4First && b <= Lead4Last) return 4;
      return 0;
   endfunction

   function automatic void emit(logic [7:0] b);
      rsp_type r;
      r.out_byte    = b;
      r.byte_valid  = 1'b1;
      r.end_of_text = 1'b0;
      cleaned_q.push_back(r);
      step_bytes++;
   endfunction

   function automatic void emit_due_space();
      if (space_due) emit(SpaceByte);
      space_due  = 1'b0;
      wrote_char = 1'b1;
   endfunction

   function automatic void judge_alone(logic [7:0] b);
      int len;
      if (b <= SpaceByte || b == DelByte) begin
         space_due = wrote_char;
         return;
      end
      len = char_length(b);
      if (len == 1) begin
         emit_due_space();
         emit(b);
      end else if (len > 1) begin
         lead_hold = b;
         hold_len  = 2'd1;
      end
   endfunction

   function automatic void clear_text_state();
      lead_hold    = '0;
      cont_hold[0] = '0;
      cont_hold[1] = '0;
      hold_len     = '0;
      skip_next    = 1'b0;
      space_due    = 1'b0;
      wrote_char   = 1'b0;
   endfunction

   function automatic void sanitize_byte(req_type r);
      logic [7:0] b;
      int         pos;
      int         len;
      logic       ok;
      rsp_type    tail;
      b          = r.data_byte;
      step_bytes = 0;
      if (skip_next) begin
         skip_next = 1'b0;
      end else if (hold_len != 0) begin
         pos = int'(hold_len);
         len = char_length(lead_hold);
         if (lead_hold == MarkLead && pos == 1 && b == MarkTail) begin
            hold_len  = '0;
            skip_next = 1'b1;
         end else begin
            ok = (b[7:6] == 2'b10);
            if (pos == 1 && ((lead_hold == Lead3First && b < Cont3Limit) ||
                             (lead_hold == SurrLead && b >= Cont3Limit) ||
                             (lead_hold == Lead4First && b < Cont4Limit) ||
                             (lead_hold == Lead4Last && b >= Cont4Limit)))
               ok = 1'b0;
            if (!ok) begin
               hold_len = '0;
               judge_alone(b);
            end else if (pos + 1 >= len) begin
               emit_due_space();
               emit(lead_hold);
               for (int k = 0; k + 1 < pos; k++) emit(cont_hold[k]);
               emit(b);
               hold_len = '0;
            end else begin
               cont_hold[pos-1] = b;
               hold_len         = 2'(pos + 1);
            end
         end
      end else begin
         judge_alone(b);
      end
      if (r.final_byte) begin
         if (step_bytes == 0) begin
            tail.out_byte    = '0;
            tail.byte_valid  = 1'b0;
            tail.end_of_text = 1'b1;
         end else begin
            tail             = cleaned_q.pop_back();
            tail.end_of_text = 1'b1;
         end
         cleaned_q.push_back(tail);
         clear_text_state();
      end
   endfunction

   function automatic logic [7:0] pick(int lo, int hi);
      return 8'($urandom_range(hi, lo));
   endfunction

   // well-formed character of the given length with random content
   function automatic void make_char(int len);
      logic [7:0] lead;
      logic [7:0] second;
      char_q.delete();
      if (len == 1) begin
         char_q.push_back(pick(8'h21, 8'h7e));
      end else if (len == 2) begin
         char_q.push_back(pick(MarkLead, Lead2Last));
         char_q.push_back(pick(8'h80, 8'hbf));
      end else if (len == 3) begin
         lead = pick(Lead3First, Lead3Last);
         if (lead == Lead3First) second = pick(Cont3Limit, 8'hbf);
         else if (lead == SurrLead) second = pick(8'h80, 8'h9f);
         else second = pick(8'h80, 8'hbf);
         char_q.push_back(lead);
         char_q.push_back(second);
         char_q.push_back(pick(8'h80, 8'hbf));
      end else begin
         lead = pick(Lead4First, Lead4Last);
         if (lead == Lead4First) second = pick(Cont4Limit, 8'hbf);
         else if (lead == Lead4Last) second = pick(8'h80, 8'h8f);
         else second = pick(8'h80, 8'hbf);
         char_q.push_back(lead);
         char_q.push_back(second);
         char_q.push_back(pick(8'h80, 8'hbf));
         char_q.push_back(pick(8'h80, 8'hbf));
      end
   endfunction

   function automatic void add_token();
      int roll;
      int keep;
      roll = $urandom_range(99);
      if (roll < 64) begin
         make_char(roll < 30 ? 1 : roll < 42 ? 2 : roll < 54 ? 3 : 4);
         foreach (char_q[i]) text_q.push_back(char_q[i]);
      end else if (roll < 72) begin
         make_char($urandom_range(4, 2));
         keep = $urandom_range(char_q.size() - 1, 1);
         for (int i = 0; i < keep; i++) text_q.push_back(char_q[i]);
      end else if (roll < 82) begin
         text_q.push_back($urandom_range(9) == 0 ? DelByte : pick(0, SpaceByte));
      end else if (roll < 88) begin
         text_q.push_back(MarkLead);
         text_q.push_back(MarkTail);
         text_q.push_back(pick(0, 255));
      end else if (roll < 94) begin
         case ($urandom_range(3))
            0: begin
               text_q.push_back(Lead3First);
               text_q.push_back(pick(8'h80, Cont3Limit - 1));
            end
            1: begin
               text_q.push_back(SurrLead);
               text_q.push_back(pick(Cont3Limit, 8'hbf));
            end
            2: begin
               text_q.push_back(Lead4First);
               text_q.push_back(pick(8'h80, Cont4Limit - 1));
            end
            default: begin
               text_q.push_back(Lead4Last);
               text_q.push_back(pick(Cont4Limit, 8'hbf));
            end
         endcase
      end else begin
         text_q.push_back(pick(0, 255));
      end
   endfunction

   function automatic void build_text(int n_tokens);
      text_q.delete();
      repeat (n_tokens) add_token();
   endfunction

   function automatic void load_text(logic [63:0] packed_bytes, int n);
      text_q.delete();
      for (int i = n - 1; i >= 0; i--) text_q.push_back(packed_bytes[8*i +: 8]);
   endfunction

   task automatic send_item(req_type item);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      sanitize_byte(item);
      bytes_sent++;
   endtask

   task automatic send_span(int from, int upto);
      req_type item;
      for (int i = from; i < upto; i++) begin
         item.data_byte  = text_q[i];
         item.final_byte = (i == text_q.size() - 1);
         send_item(item);
         if (item.final_byte) texts_sent++;
      end
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (cleaned_q.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic run_random_texts(int n_bytes);
      int target;
      target = bytes_sent + n_bytes;
      while (bytes_sent < target) begin
         build_text($urandom_range(10, 1));
         send_span(0, text_q.size());
      end
      wait_drained();
   endtask

   task automatic test_directed();
      idle_pct  = 0;
      stall_pct = 0;
      // leading control, owed space, invalid lead, two-byte char, trailing space
      load_text(64'h00_41_7f_ff_df_bf_20, 7);
      send_span(0, text_q.size());
      // surrogate break, highest code point ending the text
      load_text(64'hed_a0_f4_8f_bf_bf, 6);
      send_span(0, text_q.size());
      // mark eats the next byte, then a mark whose skipped byte is final
      load_text(64'hc2_a7_c2_41_c2_a7_7e, 7);
      send_span(0, text_q.size());
      // mark ending the text
      load_text(64'hc2_a7, 2);
      send_span(0, text_q.size());
      // overlong break, then a sequence cut off at the end
      load_text(64'he0_9f_f0_90_80, 5);
      send_span(0, text_q.size());
      wait_drained();
   endtask

   task automatic test_streaming();
      idle_pct  = 0;
      stall_pct = 0;
      run_random_texts(80);
   endtask

   task automatic test_sender_gaps();
      idle_pct  = 55;
      stall_pct = 0;
      run_random_texts(100);
   endtask

   task automatic test_receiver_stalls();
      idle_pct  = 0;
      stall_pct = 55;
      run_random_texts(100);
   endtask

   task automatic test_mixed_gaps();
      idle_pct  = 8;
      stall_pct = 8;
      run_random_texts(80);
   endtask

   task automatic test_backpressure();
      int half;
      idle_pct   = 0;
      stall_pct  = 0;
      hold_armed = 1'b1;
      build_text(24);
      send_span(0, text_q.size());
      wait_drained();
      // pause mid-text until everything has drained, then finish the text
      build_text(12);
      half = text_q.size() / 2;
      send_span(0, half);
      wait_drained();
      send_span(half, text_q.size());
      wait_drained();
   endtask

   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_armed) begin
            hold_armed = 1'b0;
            repeat (HoldCycles) begin
               rsp_stall <= 1'b1;
               @(negedge clock);
            end
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   function automatic void note_mismatch(string why, rsp_type want, rsp_type got);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch (%s): expected byte %02h valid %0b eot %0b, got byte %02h valid %0b eot %0b",
                  why, want.out_byte, want.byte_valid, want.end_of_text,
                  got.out_byte, got.byte_valid, got.end_of_text);
   endfunction

   always @(posedge clock) begin : check_cleaned
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         bytes_out++;
         if (rsp_data.end_of_text) markers++;
         if (cleaned_q.size() == 0) begin
            note_mismatch("nothing expected", '0, rsp_data);
         end else begin
            want = cleaned_q.pop_front();
            if (rsp_data.out_byte !== want.out_byte ||
                rsp_data.byte_valid !== want.byte_valid ||
                rsp_data.end_of_text !== want.end_of_text)
               note_mismatch("wrong field", want, rsp_data);
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      wait (reset == 1'b0);
      while (quiet < QuietLimit) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
      end
      $display("stalled for %0d cycles with %0d results outstanding", quiet, cleaned_q.size());
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      clear_text_state();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_streaming();
      test_sender_gaps();
      test_receiver_stalls();
      test_mixed_gaps();
      test_backpressure();
      $display("%0d texts, %0d bytes in, %0d results out, %0d end markers, %0d mismatches",
               texts_sent, bytes_sent, bytes_out, markers, mismatches);
      $display("ran streaming, sender gaps, receiver stalls, mixed gaps and a long output hold");
      if (mismatches == 0 && cleaned_q.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
